// ----- src/htd_pkg.sv -----
// htd_pkg: shared types and constants of the hot thread detector
// no dependencies; used by htd_cell and hot_thread_detector

package htd_pkg;

   localparam int ID_W     = 32;
   localparam int CTIME_W  = 64;
   localparam int STREAK_W = 8;
   localparam int CONF_W   = 8;

   localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

   // one thread entry: id and accumulated cpu time
   typedef struct packed {
      logic [ID_W-1:0]    tid;
      logic [CTIME_W-1:0] ctime;
   } entry_type;

   // contents of one chain cell: entry of the previous snapshot and of the current one
   typedef struct packed {
      entry_type prev;
      entry_type cur;
   } cell_type;

endpackage

// ----- src/htd_cell.sv -----
// htd_cell: one storage cell of the rotating snapshot chain
// depends on htd_pkg (cell_type)

module htd_cell (
   input  logic              clock,
   input  logic              shift_en,   // take the neighbor's contents
   input  logic              copy_en,    // current entry becomes previous entry
   input  htd_pkg::cell_type nb_d,
   output htd_pkg::cell_type cell_q
);

   htd_pkg::cell_type cell_ff;
   htd_pkg::cell_type cell_in;

   always_comb begin
      cell_in = cell_ff;
      if (shift_en) begin
         cell_in = nb_d;
      end else if (copy_en) begin
         cell_in.prev = cell_ff.cur;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_q = cell_ff;

endmodule

// ----- src/hot_thread_detector.sv -----
// hot_thread_detector: top level, control, delta compare and streak gate
// depends on htd_pkg and htd_cell
// usage
//   req channel: one beat per thread entry of a snapshot. tdata carries the
//   thread id and its cpu time, tlast marks the final entry, tuser set means
//   an empty snapshot beat (id and time ignored) that just closes the snapshot.
//   rsp channel: one beat per closed snapshot with the committed hot thread id
//   (0 until one is committed) and the current streak.
//   csr port: csr_wr_data is written into confidence_min whenever csr_wr_en
//   is high; the user must write it only while idle; the block does not check.
// sequence
//   the previous snapshot sits in a ring of MAX_THREADS cells that rotates one
//   full turn per entry: an entry is accepted, the ring turns once and the
//   pipeline drains. a closing beat then updates the streak and loads the
//   response register. entries beyond MAX_THREADS in one snapshot are
//   accepted and dropped without a turn of the ring.
// reset
//   clears counts, streak, candidate and committed thread; confidence_min
//   returns to 2. cell contents are not cleared, only counted entries are read.
// back-pressure
//   the response is held in an output register; entries keep being accepted
//   while it waits, only a second snapshot close stalls until rsp is taken.

module hot_thread_detector #(
   parameter int MAX_THREADS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // req
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // [31:0] tid, [95:32] cpu_time
   input  logic        req_tlast,   // last_entry
   input  logic        req_tuser,   // empty_snapshot
   // rsp
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] hot_tid, [39:32] streak
   // csr
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data  // confidence_min
);

   localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CNT_W = $clog2(MAX_THREADS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_THREADS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_THREADS);
   localparam logic [htd_pkg::CONF_W-1:0] CONF_RESET = 8'd2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // control state
   state_type                       state_ff, state_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [CNT_W-1:0]                prev_cnt_ff, prev_cnt_in;
   logic [CNT_W-1:0]                cur_cnt_ff, cur_cnt_in;
   logic                            found_ff, found_in;
   logic                            s1_valid_ff, s1_valid_in;
   logic [htd_pkg::CTIME_W-1:0]     best_delta_ff, best_delta_in;
   logic [htd_pkg::ID_W-1:0]        best_thread_ff, best_thread_in;
   logic [htd_pkg::ID_W-1:0]        cand_ff, cand_in;
   logic [htd_pkg::STREAK_W-1:0]    streak_ff, streak_in;
   logic [htd_pkg::ID_W-1:0]        committed_ff, committed_in;
   logic [htd_pkg::CONF_W-1:0]      conf_ff, conf_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [htd_pkg::ID_W-1:0]        q_id_ff, q_id_in;
   logic [htd_pkg::CTIME_W-1:0]     q_time_ff, q_time_in;
   logic                            q_last_ff, q_last_in;
   logic [htd_pkg::CTIME_W-1:0]     s1_delta_ff, s1_delta_in;
   logic [htd_pkg::ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [htd_pkg::STREAK_W-1:0]    rsp_streak_ff, rsp_streak_in;

   // cell ring
   htd_pkg::cell_type cell_q [MAX_THREADS];
   htd_pkg::cell_type cell_d [MAX_THREADS];
   htd_pkg::cell_type head_feed;
   logic              shift_en;
   logic              fin_go;
   logic              write_here;
   logic              in_prev;
   logic              hit;
   logic [htd_pkg::CTIME_W:0] sub;
   logic [htd_pkg::STREAK_W-1:0] streak_new;
   logic [htd_pkg::ID_W-1:0]     cand_new;

   assign shift_en   = (state_ff == ST_SCAN);
   assign fin_go     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE);

   // the head cell holds logical entry idx_ff; the new entry lands at cur_cnt
   assign write_here = (CNT_W'(idx_ff) == cur_cnt_ff);
   always_comb begin
      head_feed = cell_q[0];
      if (write_here) begin
         head_feed.cur.tid   = q_id_ff;
         head_feed.cur.ctime = q_time_ff;
      end
   end

   genvar k;
   generate
      for (k = 0; k < MAX_THREADS; k++) begin : g_cell
         if (k == MAX_THREADS - 1) begin : g_tail
            assign cell_d[k] = head_feed;
         end else begin : g_mid
            assign cell_d[k] = cell_q[k+1];
         end
         htd_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .copy_en  (fin_go),
            .nb_d     (cell_d[k]),
            .cell_q   (cell_q[k])
         );
      end
   endgenerate

   // stage 1: id match at the head, delta of the first match only
   assign in_prev = (CNT_W'(idx_ff) < prev_cnt_ff);
   assign hit     = shift_en && in_prev && !found_ff && (cell_q[0].prev.tid == q_id_ff);
   assign sub     = {1'b0, q_time_ff} - {1'b0, cell_q[0].prev.ctime};

   // streak gate for the snapshot close
   always_comb begin
      streak_new = streak_ff;
      cand_new   = cand_ff;
      if (best_thread_ff == cand_ff) begin
         if (streak_ff < htd_pkg::STREAK_MAX) begin
            streak_new = streak_ff + 1'b1;
         end
      end else begin
         cand_new   = best_thread_ff;
         streak_new = 8'd1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      prev_cnt_in    = prev_cnt_ff;
      cur_cnt_in     = cur_cnt_ff;
      found_in       = found_ff;
      s1_valid_in    = hit && !sub[htd_pkg::CTIME_W] && (sub[htd_pkg::CTIME_W-1:0] != '0);
      s1_delta_in    = sub[htd_pkg::CTIME_W-1:0];
      best_delta_in  = best_delta_ff;
      best_thread_in = best_thread_ff;
      cand_in        = cand_ff;
      streak_in      = streak_ff;
      committed_in   = committed_ff;
      conf_in        = csr_wr_en ? csr_wr_data : conf_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      q_id_in        = q_id_ff;
      q_time_in      = q_time_ff;
      q_last_in      = q_last_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_streak_in  = rsp_streak_ff;

      if (hit) begin
         found_in = 1'b1;
      end

      // stage 2: running maximum, ties keep the earlier winner
      if (s1_valid_ff && (s1_delta_ff > best_delta_ff)) begin
         best_delta_in  = s1_delta_ff;
         best_thread_in = q_id_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               q_id_in   = req_tdata[31:0];
               q_time_in = req_tdata[95:32];
               q_last_in = req_tlast;
               found_in  = 1'b0;
               idx_in    = '0;
               if (req_tuser) begin
                  state_in = ST_FINISH;
               end else if (cur_cnt_ff == FULL_CNT) begin
                  state_in = req_tlast ? ST_FINISH : ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            cur_cnt_in = cur_cnt_ff + 1'b1;
            state_in   = q_last_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (fin_go) begin
               if (best_thread_ff != '0) begin
                  cand_in   = cand_new;
                  streak_in = streak_new;
                  if (streak_new >= conf_ff) begin
                     committed_in = best_thread_ff;
                  end
               end
               rsp_id_in      = ((best_thread_ff != '0) && (streak_new >= conf_ff))
                                ? best_thread_ff : committed_ff;
               rsp_streak_in  = (best_thread_ff != '0) ? streak_new : streak_ff;
               rsp_valid_in   = 1'b1;
               prev_cnt_in    = cur_cnt_ff;
               cur_cnt_in     = '0;
               best_delta_in  = '0;
               best_thread_in = '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         prev_cnt_ff    <= '0;
         cur_cnt_ff     <= '0;
         found_ff       <= 1'b0;
         s1_valid_ff    <= 1'b0;
         best_delta_ff  <= '0;
         best_thread_ff <= '0;
         cand_ff        <= '0;
         streak_ff      <= '0;
         committed_ff   <= '0;
         conf_ff        <= CONF_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         prev_cnt_ff    <= prev_cnt_in;
         cur_cnt_ff     <= cur_cnt_in;
         found_ff       <= found_in;
         s1_valid_ff    <= s1_valid_in;
         best_delta_ff  <= best_delta_in;
         best_thread_ff <= best_thread_in;
         cand_ff        <= cand_in;
         streak_ff      <= streak_in;
         committed_ff   <= committed_in;
         conf_ff        <= conf_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_id_ff       <= q_id_in;
      q_time_ff     <= q_time_in;
      q_last_ff     <= q_last_in;
      s1_delta_ff   <= s1_delta_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_streak_ff <= rsp_streak_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_streak_ff, rsp_id_ff};

   // entry count never passes the ring size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cur_cnt_ff <= FULL_CNT)
      else $error("current entry count beyond ring size");

   // a snapshot close leaves a fresh running maximum and an empty current count
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> (cur_cnt_ff == '0 && best_thread_ff == '0 && best_delta_ff == '0))
      else $error("snapshot close did not clear running state");

   // a response only appears out of a snapshot close
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside snapshot close");

   // a committed thread implies a running streak
   a_commit_streak: assert property (@(posedge clock) disable iff (reset)
      (committed_ff != '0) |-> (streak_ff != '0))
      else $error("committed thread without streak");

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for hot_thread_detector, driven over its req/rsp streams
// depends on htd_pkg and hot_thread_detector; holds its own predictor of the snapshot logic
`timescale 1ns / 1ps

module tb;

   localparam int MAXT = 64;

   // one req beat as the generator sees it
   typedef struct {
      logic [htd_pkg::ID_W-1:0]    tid;
      logic [htd_pkg::CTIME_W-1:0] ctime;
      logic                        last;
      logic                        empty;
   } beat_type;

   // one expected rsp beat
   typedef struct {
      logic [htd_pkg::ID_W-1:0]     hot;
      logic [htd_pkg::STREAK_W-1:0] streak;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;    // [31:0] tid, [95:32] cpu_time
   logic        req_tlast = 1'b0;  // last_entry
   logic        req_tuser = 1'b0;  // empty_snapshot
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [31:0] hot_tid, [39:32] streak
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;  // confidence_min

   hot_thread_detector #(.MAX_THREADS(MAXT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // beats waiting to be driven, and snapshot results still owed by the block
   beat_type    snapshot_beats[$];
   verdict_type pending_verdicts[$];

   int errors = 0;
   int beats_queued = 0;
   int beats_accepted = 0;
   int verdicts_checked = 0;
   int conf_writes = 0;

   // handshakes seen at the last rising edge, read at the following falling edge
   bit req_took = 0;
   bit rsp_took = 0;

   // ------------------------------------------------------------------
   // predictor state: two banks of thread entries, running maximum, streak gate
   // ------------------------------------------------------------------
   logic [htd_pkg::ID_W-1:0]     snap_ids   [2][MAXT];
   logic [htd_pkg::CTIME_W-1:0]  snap_times [2][MAXT];
   int                           prev_bank = 0;
   int                           prev_cnt = 0;
   int                           cur_cnt = 0;
   logic [htd_pkg::CTIME_W-1:0]  lead_delta = '0;
   logic [htd_pkg::ID_W-1:0]     lead_thread = '0;
   logic [htd_pkg::ID_W-1:0]     cand_thread = '0;
   logic [htd_pkg::ID_W-1:0]     committed = '0;
   logic [htd_pkg::STREAK_W-1:0] streak = '0;
   logic [htd_pkg::CONF_W-1:0]   conf_min = 8'd2;

   // fold one accepted beat into the predictor; a closing beat yields a verdict
   task automatic absorb_beat(input beat_type b);
      verdict_type                 v;
      int                          cur_bank;
      bit                          hit;
      logic [htd_pkg::CTIME_W-1:0] d;
      cur_bank = 1 - prev_bank;
      if (!b.empty && cur_cnt < MAXT) begin
         // only the first stored match of the previous snapshot counts
         hit = 0;
         for (int i = 0; i < prev_cnt; i++) begin
            if (!hit && snap_ids[prev_bank][i] == b.tid) begin
               hit = 1;
               if (b.ctime > snap_times[prev_bank][i]) begin
                  d = b.ctime - snap_times[prev_bank][i];
                  // strict compare: a tie keeps the earlier winner
                  if (d > lead_delta) begin
                     lead_delta = d;
                     lead_thread = b.tid;
                  end
               end
            end
         end
         snap_ids[cur_bank][cur_cnt] = b.tid;
         snap_times[cur_bank][cur_cnt] = b.ctime;
         cur_cnt++;
      end
      if (b.empty || b.last) begin
         // id zero as winner counts as no winner, whether nobody grew or thread zero led
         if (lead_thread != '0) begin
            if (lead_thread == cand_thread) begin
               if (streak < htd_pkg::STREAK_MAX) streak = streak + 1'b1;
            end else begin
               cand_thread = lead_thread;
               streak = 8'd1;
            end
            if (streak >= conf_min) committed = lead_thread;
         end
         prev_bank = cur_bank;
         prev_cnt = cur_cnt;
         cur_cnt = 0;
         lead_delta = '0;
         lead_thread = '0;
         v.hot = committed;
         v.streak = streak;
         pending_verdicts.push_back(v);
      end
   endtask

   // gap picker: mostly none or short, a few long, and calm stretches with none
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(30, 150);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 20);
      return $urandom_range(30, 120);
   endfunction

   // ------------------------------------------------------------------
   // req driver: holds a beat until taken, then idles for a random gap
   // ------------------------------------------------------------------
   int       send_wait = 0;
   int       send_calm = 0;
   beat_type drv_beat;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (send_wait > 0) begin
            send_wait--;
            req_tvalid <= 1'b0;
         end else if (snapshot_beats.size() > 0) begin
            drv_beat = snapshot_beats.pop_front();
            req_tdata <= {drv_beat.ctime, drv_beat.tid};
            req_tlast <= drv_beat.last;
            req_tuser <= drv_beat.empty;
            req_tvalid <= 1'b1;
            send_wait = pick_gap(send_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // rsp receiver: random stalls after each beat, plus one long hold-off
   // that lets the output register fill and back up the req side
   // ------------------------------------------------------------------
   int recv_wait = 0;
   int recv_calm = 0;
   int hold_left = 0;
   bit pressure_done = 0;

   always @(negedge clock) begin
      if (rsp_took) recv_wait = pick_gap(recv_calm);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!pressure_done && verdicts_checked >= 25) begin
         pressure_done = 1;
         hold_left = 2000;
         rsp_tready <= 1'b0;
      end else if (recv_wait > 0) begin
         recv_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // monitor: predict on every accepted req beat, check every rsp beat
   // ------------------------------------------------------------------
   beat_type    mon_beat;
   verdict_type want;

   always @(posedge clock) begin
      req_took = !reset && req_tvalid && req_tready;
      rsp_took = !reset && rsp_tvalid && rsp_tready;
      if (req_took) begin
         mon_beat.tid = req_tdata[31:0];
         mon_beat.ctime = req_tdata[95:32];
         mon_beat.last = req_tlast;
         mon_beat.empty = req_tuser;
         absorb_beat(mon_beat);
         beats_accepted++;
      end
      if (rsp_took) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected rsp beat, expected none, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[31:0] !== want.hot) begin
               $display("%0t: hot thread mismatch, expected %h, got %h",
                        $time, want.hot, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[39:32] !== want.streak) begin
               $display("%0t: streak mismatch, expected %0d, got %0d",
                        $time, want.streak, rsp_tdata[39:32]);
               errors++;
            end
         end
         verdicts_checked++;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_beat(input logic [31:0] tid, input logic [63:0] ctime,
                             input logic last, input logic empty);
      beat_type b;
      b.tid = tid;
      b.ctime = ctime;
      b.last = last;
      b.empty = empty;
      snapshot_beats.push_back(b);
      beats_queued++;
   endtask

   // empty-snapshot beat with junk in the ignored fields
   task automatic queue_close();
      queue_beat($urandom, {$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'b1);
   endtask

   // block is idle once every beat is taken and every verdict has come back
   task automatic wait_drained();
      while (beats_accepted != beats_queued || pending_verdicts.size() != 0)
         @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_conf(input logic [7:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      conf_min = value;
      conf_writes++;
   endtask

   // small world of threads whose times mostly grow; one of them runs hot
   logic [31:0] pool_id   [96];
   logic [63:0] pool_time [96];

   task automatic gen_phase(input int n_items, input int pool_n, input bit wide);
      int          stop_at, size, k, hot, r;
      logic [31:0] tid;
      logic [63:0] ctime;
      bit          split_close;
      stop_at = beats_queued + n_items;
      for (int i = 0; i < pool_n; i++) begin
         pool_id[i] = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 4000);
         pool_time[i] = {2'b00, 30'($urandom), 32'($urandom)};
      end
      hot = $urandom_range(0, pool_n - 1);
      while (beats_queued < stop_at) begin
         if ($urandom_range(0, 32) == 0) hot = $urandom_range(0, pool_n - 1);
         // a snapshot with no threads at all
         if (!wide && $urandom_range(0, 19) == 0) begin
            queue_close();
            continue;
         end
         r = $urandom_range(0, 99);
         if (wide) size = $urandom_range(MAXT + 1, MAXT + 8);
         else if (r < 70) size = $urandom_range(1, 6);
         else if (r < 95) size = $urandom_range(7, 16);
         else size = $urandom_range(17, 40);
         // sometimes the snapshot ends on an empty beat instead of tlast
         split_close = ($urandom_range(0, 9) == 0);
         for (int e = 0; e < size; e++) begin
            k = ($urandom_range(0, 2) == 0) ? hot : $urandom_range(0, pool_n - 1);
            r = $urandom_range(0, 99);
            if (r < 70) begin
               pool_time[k] += (k == hot) ? $urandom_range(5000, 50000)
                                          : $urandom_range(0, 4000);
               tid = pool_id[k];
               ctime = pool_time[k];
            end else if (r < 82) begin
               tid = pool_id[k];
               ctime = pool_time[k];
            end else if (r < 88) begin
               pool_time[k] -= $urandom_range(1, 1000);
               tid = pool_id[k];
               ctime = pool_time[k];
            end else if (r < 94) begin
               tid = $urandom;
               ctime = {$urandom, $urandom};
            end else begin
               tid = '0;
               ctime = pool_time[k] + $urandom_range(0, 100000);
            end
            queue_beat(tid, ctime, (e == size - 1) && !split_close, 1'b0);
         end
         if (split_close) queue_close();
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   logic [31:0] sat_id;
   logic [63:0] sat_time;

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed part, confidence_min at its reset value
      // empty snapshot straight after reset
      queue_beat(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
      // first real snapshot: nothing to compare against
      queue_beat(32'h11, 64'd100, 1'b0, 1'b0);
      queue_beat(32'h0, 64'd0, 1'b0, 1'b0);
      queue_beat(32'hFFFF_FFFF, 64'd0, 1'b0, 1'b0);
      queue_beat(32'h22, 64'd50, 1'b1, 1'b0);
      // time not grown, full-range delta, id zero, shrunk time, duplicate id
      queue_beat(32'h11, 64'd100, 1'b0, 1'b0);
      queue_beat(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
      queue_beat(32'h0, 64'd5, 1'b0, 1'b0);
      queue_beat(32'h22, 64'd40, 1'b0, 1'b0);
      queue_beat(32'h22, 64'd60, 1'b1, 1'b0);
      // thread zero grows the most, so no winner
      queue_beat(32'h0, 64'd100, 1'b0, 1'b0);
      queue_beat(32'h11, 64'd100, 1'b0, 1'b0);
      queue_beat(32'h22, 64'd60, 1'b0, 1'b0);
      queue_beat(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
      // tie on equal deltas, closed by an empty beat after entries
      queue_beat(32'h22, 64'd160, 1'b0, 1'b0);
      queue_beat(32'h11, 64'd200, 1'b0, 1'b0);
      queue_beat(32'h0, 64'h0, 1'b0, 1'b1);
      // same winner again commits at threshold two
      queue_beat(32'h22, 64'd170, 1'b0, 1'b0);
      queue_beat(32'h11, 64'd205, 1'b1, 1'b0);
      // empty snapshot with tlast low and junk data, then a lone entry
      queue_beat(32'hA5A5_5A5A, 64'h5A5A_A5A5_0F0F_F0F0, 1'b0, 1'b1);
      queue_beat(32'h22, 64'd1000, 1'b1, 1'b0);
      wait_drained();

      // random snapshots, commit on first lead
      write_conf(8'd1);
      gen_phase(330, $urandom_range(2, 10), 1'b0);
      wait_drained();

      // one thread leads long enough to commit at the top threshold and saturate
      write_conf(8'd255);
      sat_id = $urandom | 32'h1;
      sat_time = {8'h00, 24'($urandom), 32'($urandom)};
      for (int s = 0; s < 262; s++) begin
         sat_time += $urandom_range(1, 100);
         queue_beat(sat_id, sat_time, 1'b1, 1'b0);
      end
      wait_drained();

      // threshold zero acts like one
      write_conf(8'd0);
      gen_phase(330, $urandom_range(2, 10), 1'b0);
      wait_drained();

      // snapshots longer than the store; the excess is dropped
      write_conf(8'd1);
      gen_phase(200, 90, 1'b1);
      wait_drained();

      write_conf(8'd3);
      gen_phase(330, $urandom_range(2, 10), 1'b0);
      wait_drained();

      write_conf(8'($urandom_range(1, 8)));
      gen_phase(250, $urandom_range(2, 16), 1'b0);
      wait_drained();

      if (pending_verdicts.size() != 0) begin
         $display("%0t: %0d snapshot results never arrived", $time, pending_verdicts.size());
         errors++;
      end
      $display("covered %0d req beats and %0d snapshot results over %0d threshold settings",
               beats_accepted, verdicts_checked, conf_writes + 1);
      $display("including long snapshots, a saturated streak and a stalled rsp side");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", errors);
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #40000000;
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule
